// File: hdl/linear_probing_hash_table_core_defines.svh
// Assertion macros used by the hash table core.
`ifndef LINEAR_PROBING_HASH_TABLE_CORE_DEFINES_SVH
`define LINEAR_PROBING_HASH_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset
`define LPHT_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hash table assertion failed");

// Next-cycle implication, sampled on clock, off during reset
`define LPHT_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hash table assertion failed");

`endif

// File: hdl/lpht_pkg.sv
// Types, widths and codes shared by the hash table modules.
package lpht_pkg;

   localparam int OP_W        = 2;
   localparam int KEY_W       = 31;
   localparam int VALUE_W     = 64;
   localparam int STATUS_W    = 2;
   localparam int SIZE_W      = 7;
   localparam int SLOT_OUT_W  = 6;
   localparam int REQ_TDATA_W = 96;
   localparam int RSP_TDATA_W = 104;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
   localparam logic [OP_W-1:0] OP_SEARCH  = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE  = 2'd2;
   localparam logic [OP_W-1:0] OP_DISPLAY = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   // One slot of key and payload storage
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } entry_type;

   // Remainder unit result
   typedef struct packed {
      logic              done;
      logic [SIZE_W-1:0] rem;
   } mod_rsp_type;

endpackage

// File: hdl/linear_probing_hash_table_core.sv
// Linear probing hash table: insert, search, delete and display over a slot memory.
// Insert: the remainder unit forms the home slot, then one cycle per occupied slot passed (k <= n);
// the result is registered once a free slot or a full table is found and the output is free.
// Search/delete: one slot read per cycle from slot 0; stops at the first key hit, else a miss.
// Display: one slot per cycle unless a stalled output holds the scan; the last result has tlast.
// Reset clears all valid marks at once and sets table_size to 64; no clearing pass.
`include "linear_probing_hash_table_core_defines.svh"

module linear_probing_hash_table_core #(
   parameter int SLOTS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration: table_size
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lpht_pkg::SIZE_W-1:0]         csr_data,
   // Request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lpht_pkg::REQ_TDATA_W-1:0]    req_tdata,  // key[30:0], value[94:31], pad
   input  logic [lpht_pkg::OP_W-1:0]           req_tuser,  // op[1:0]
   // Response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lpht_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // slot[5:0], found_key[36:6],
                                                           // found_value[100:37], pad
   output logic [lpht_pkg::STATUS_W-1:0]       rsp_tuser,  // status[1:0]
   output logic                                rsp_tlast
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam logic [lpht_pkg::SIZE_W-1:0] SLOTS_SZ = lpht_pkg::SIZE_W'(SLOTS);
   localparam int PAD_W  = lpht_pkg::RSP_TDATA_W - lpht_pkg::SLOT_OUT_W
                           - lpht_pkg::KEY_W - lpht_pkg::VALUE_W;

   // Controller states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MOD   = 3'd1;
   localparam logic [2:0] ST_PROBE = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_FINAL = 3'd4;

   logic [2:0]                        state_ff, state_in;
   logic [lpht_pkg::SIZE_W-1:0]       size_ff, size_in;
   logic [lpht_pkg::OP_W-1:0]         op_ff, op_in;
   logic [lpht_pkg::KEY_W-1:0]        key_ff, key_in;
   logic [lpht_pkg::VALUE_W-1:0]      value_ff, value_in;
   logic [SLOTS-1:0]                  valid_ff, valid_in;
   logic [SLOT_W-1:0]                 probe_pos_ff, probe_pos_in;
   logic [CNT_W-1:0]                  probe_cnt_ff, probe_cnt_in;
   logic [CNT_W-1:0]                  rd_ptr_ff, rd_ptr_in;
   logic                              cmp_vld_ff, cmp_vld_in;
   logic [SLOT_W-1:0]                 cmp_idx_ff, cmp_idx_in;
   logic                              pend_vld_ff, pend_vld_in;
   logic [SLOT_W-1:0]                 pend_idx_ff, pend_idx_in;
   lpht_pkg::entry_type               pend_ent_ff, pend_ent_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [lpht_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [lpht_pkg::SLOT_OUT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [lpht_pkg::KEY_W-1:0]        rsp_key_ff, rsp_key_in;
   logic [lpht_pkg::VALUE_W-1:0]      rsp_value_ff, rsp_value_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic [lpht_pkg::SIZE_W-1:0]       n_eff;
   logic                              out_free;
   logic                              req_xfer;
   logic                              emit;
   logic [lpht_pkg::STATUS_W-1:0]     e_status;
   logic [SLOT_W-1:0]                 e_slot;
   lpht_pkg::entry_type               e_ent;
   logic                              e_last;
   logic                              ins_wr;
   logic                              rd_en;
   logic                              entry_hit;
   logic                              key_hit;
   logic                              scan_done;
   logic                              mod_start;
   lpht_pkg::mod_rsp_type             mod_rsp;
   lpht_pkg::entry_type               rd_data;
   lpht_pkg::entry_type               wr_data;

   // Effective table size: zero acts as one, cap at the slot count
   always_comb begin
      if (size_ff == '0) begin
         n_eff = lpht_pkg::SIZE_W'(1);
      end else if (size_ff > SLOTS_SZ) begin
         n_eff = SLOTS_SZ;
      end else begin
         n_eff = size_ff;
      end
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign mod_start  = req_xfer && (req_tuser == lpht_pkg::OP_INSERT);

   assign entry_hit = cmp_vld_ff && valid_ff[cmp_idx_ff];
   assign key_hit   = entry_hit && (rd_data.key == key_ff);
   assign scan_done = !cmp_vld_ff && (lpht_pkg::SIZE_W'(rd_ptr_ff) >= n_eff);

   assign wr_data.key   = key_ff;
   assign wr_data.value = value_ff;

   // Home slot remainder
   lpht_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (req_tdata[lpht_pkg::KEY_W-1:0]),
      .divisor  (n_eff),
      .result   (mod_rsp)
   );

   // Key and payload storage
   lpht_slot_ram #(
      .DEPTH  (SLOTS),
      .ADDR_W (SLOT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ins_wr),
      .wr_addr (probe_pos_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff[SLOT_W-1:0]),
      .rd_data (rd_data)
   );

   // Sequence probing and scanning, and pick the result to emit
   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      valid_in     = valid_ff;
      probe_pos_in = probe_pos_ff;
      probe_cnt_in = probe_cnt_ff;
      rd_ptr_in    = rd_ptr_ff;
      cmp_vld_in   = cmp_vld_ff;
      cmp_idx_in   = cmp_idx_ff;
      pend_vld_in  = pend_vld_ff;
      pend_idx_in  = pend_idx_ff;
      pend_ent_in  = pend_ent_ff;
      emit         = 1'b0;
      e_status     = lpht_pkg::STATUS_MISS;
      e_slot       = '0;
      e_ent        = '0;
      e_last       = 1'b1;
      ins_wr       = 1'b0;
      rd_en        = 1'b0;

      if (csr_valid && csr_ready) begin
         size_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               op_in       = req_tuser;
               key_in      = req_tdata[lpht_pkg::KEY_W-1:0];
               value_in    = req_tdata[lpht_pkg::KEY_W +: lpht_pkg::VALUE_W];
               rd_ptr_in   = '0;
               cmp_vld_in  = 1'b0;
               pend_vld_in = 1'b0;
               if (req_tuser == lpht_pkg::OP_INSERT) begin
                  state_in = ST_MOD;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_MOD: begin
            if (mod_rsp.done) begin
               probe_pos_in = mod_rsp.rem[SLOT_W-1:0];
               probe_cnt_in = '0;
               state_in     = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (lpht_pkg::SIZE_W'(probe_cnt_ff) >= n_eff) begin
               // Every slot in use: report full
               if (out_free) begin
                  emit     = 1'b1;
                  e_status = lpht_pkg::STATUS_FULL;
                  state_in = ST_IDLE;
               end
            end else if (!valid_ff[probe_pos_ff]) begin
               // Free slot: write it once the result can be taken
               if (out_free) begin
                  emit       = 1'b1;
                  ins_wr     = 1'b1;
                  e_status   = lpht_pkg::STATUS_OK;
                  e_slot     = probe_pos_ff;
                  e_ent      = wr_data;
                  valid_in[probe_pos_ff] = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               // Advance with wrap at the table size
               probe_cnt_in = probe_cnt_ff + 1'b1;
               if (lpht_pkg::SIZE_W'(probe_pos_ff) + 1'b1 >= n_eff) begin
                  probe_pos_in = '0;
               end else begin
                  probe_pos_in = probe_pos_ff + 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (op_ff == lpht_pkg::OP_DISPLAY) begin
               if (entry_hit && pend_vld_ff && !out_free) begin
                  // Hold the pipeline until the output register frees
               end else begin
                  if (entry_hit) begin
                     if (pend_vld_ff) begin
                        emit     = 1'b1;
                        e_status = lpht_pkg::STATUS_OK;
                        e_slot   = pend_idx_ff;
                        e_ent    = pend_ent_ff;
                        e_last   = 1'b0;
                     end
                     pend_vld_in = 1'b1;
                     pend_idx_in = cmp_idx_ff;
                     pend_ent_in = rd_data;
                  end
                  rd_en      = (lpht_pkg::SIZE_W'(rd_ptr_ff) < n_eff);
                  cmp_vld_in = rd_en;
                  cmp_idx_in = rd_ptr_ff[SLOT_W-1:0];
                  rd_ptr_in  = rd_ptr_ff + CNT_W'(rd_en);
                  if (scan_done) begin
                     state_in = ST_FINAL;
                  end
               end
            end else begin
               if (key_hit) begin
                  // First match: report, and drop the slot on delete
                  if (out_free) begin
                     emit       = 1'b1;
                     e_status   = lpht_pkg::STATUS_OK;
                     e_slot     = cmp_idx_ff;
                     e_ent      = rd_data;
                     cmp_vld_in = 1'b0;
                     state_in   = ST_IDLE;
                     if (op_ff == lpht_pkg::OP_DELETE) begin
                        valid_in[cmp_idx_ff] = 1'b0;
                     end
                  end
               end else begin
                  rd_en      = (lpht_pkg::SIZE_W'(rd_ptr_ff) < n_eff);
                  cmp_vld_in = rd_en;
                  cmp_idx_in = rd_ptr_ff[SLOT_W-1:0];
                  rd_ptr_in  = rd_ptr_ff + CNT_W'(rd_en);
                  if (scan_done) begin
                     state_in = ST_FINAL;
                  end
               end
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               if ((op_ff == lpht_pkg::OP_DISPLAY) && pend_vld_ff) begin
                  e_status = lpht_pkg::STATUS_OK;
                  e_slot   = pend_idx_ff;
                  e_ent    = pend_ent_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load on emit, clear on transfer
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = e_status;
         rsp_slot_in   = lpht_pkg::SLOT_OUT_W'(e_slot);
         rsp_key_in    = e_ent.key;
         rsp_value_in  = e_ent.value;
         rsp_last_in   = e_last;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= lpht_pkg::SIZE_RESET;
         valid_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         valid_ff     <= valid_in;
         cmp_vld_ff   <= cmp_vld_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      probe_pos_ff  <= probe_pos_in;
      probe_cnt_ff  <= probe_cnt_in;
      rd_ptr_ff     <= rd_ptr_in;
      cmp_idx_ff    <= cmp_idx_in;
      pend_idx_ff   <= pend_idx_in;
      pend_ent_ff   <= pend_ent_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_value_ff, rsp_key_ff, rsp_slot_ff};

   // Checks
   `LPHT_ASSERT_IMP(a_emit_free, emit, (!rsp_valid_ff || rsp_tready))
   `LPHT_ASSERT_NXT(a_insert_marks, ins_wr, valid_ff[$past(probe_pos_ff)])
   `LPHT_ASSERT_IMP(a_home_in_range, mod_rsp.done, (mod_rsp.rem < n_eff))

endmodule

// File: hdl/lpht_mod_unit.sv
// Bit-serial remainder unit: key mod table size, one dividend bit per cycle.
module lpht_mod_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [lpht_pkg::KEY_W-1:0]      dividend,
   input  logic [lpht_pkg::SIZE_W-1:0]     divisor,
   output lpht_pkg::mod_rsp_type           result
);

   localparam int CNT_W = $clog2(lpht_pkg::KEY_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(lpht_pkg::KEY_W - 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [lpht_pkg::SIZE_W-1:0]   rem_ff, rem_in;
   logic [lpht_pkg::SIZE_W-1:0]   div_ff, div_in;
   logic [lpht_pkg::KEY_W-1:0]    shift_ff, shift_in;
   logic [lpht_pkg::SIZE_W:0]     trial;

   // Shift in the next dividend bit and subtract the divisor when it fits
   always_comb begin
      trial    = {rem_ff, shift_ff[lpht_pkg::KEY_W-1]};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      shift_in = shift_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         rem_in   = '0;
         div_in   = divisor;
         shift_in = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = lpht_pkg::SIZE_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[lpht_pkg::SIZE_W-1:0];
         end
         shift_in = {shift_ff[lpht_pkg::KEY_W-2:0], 1'b0};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      shift_ff <= shift_in;
   end

   assign result.done = done_ff;
   assign result.rem  = rem_ff;

endmodule

// File: hdl/lpht_slot_ram.sv
// Slot storage: one write port and one registered read port.
module lpht_slot_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  lpht_pkg::entry_type   wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output lpht_pkg::entry_type   rd_data
);

   lpht_pkg::entry_type mem [DEPTH];
   lpht_pkg::entry_type rd_data_ff;

   // Write the addressed entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register read data; hold it while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: test/tb.sv
// Self-checking testbench for the linear probing hash table core.
`timescale 1ns / 100ps

module tb;

   localparam int SLOTS        = 64;
   localparam int DRAIN_CYCLES = 128;
   localparam int POOL_DEPTH   = 48;

   // One expected or observed result transfer
   typedef struct packed {
      logic [lpht_pkg::STATUS_W-1:0]   status;
      logic [lpht_pkg::SLOT_OUT_W-1:0] slot;
      logic [lpht_pkg::KEY_W-1:0]      key;
      logic [lpht_pkg::VALUE_W-1:0]    value;
      logic                            last;
   } table_result_type;

   logic                             clock;
   logic                             reset;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [lpht_pkg::SIZE_W-1:0]      csr_data;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [lpht_pkg::REQ_TDATA_W-1:0] req_tdata;   // key[30:0], value[94:31], pad
   logic [lpht_pkg::OP_W-1:0]        req_tuser;   // op[1:0]
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [lpht_pkg::RSP_TDATA_W-1:0] rsp_tdata;   // slot[5:0], found_key[36:6],
                                                  // found_value[100:37], pad
   logic [lpht_pkg::STATUS_W-1:0]    rsp_tuser;   // status[1:0]
   logic                             rsp_tlast;

   // Shadow copy of the table and its size register
   logic [lpht_pkg::SIZE_W-1:0]  shadow_size;
   logic                         shadow_valid [SLOTS];
   logic [lpht_pkg::KEY_W-1:0]   shadow_key   [SLOTS];
   logic [lpht_pkg::VALUE_W-1:0] shadow_value [SLOTS];

   table_result_type             pending_results [$];
   logic [lpht_pkg::KEY_W-1:0]   key_pool [$];
   int                           mismatch_count = 0;
   int                           send_gap_pct   = 29;
   int                           recv_stall_pct = 85;

   linear_probing_hash_table_core #(.SLOTS(SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Work out the results of one accepted operation and update the shadow table
   function automatic void predict_table_op(input logic [lpht_pkg::OP_W-1:0] op,
                                            input logic [lpht_pkg::KEY_W-1:0] key,
                                            input logic [lpht_pkg::VALUE_W-1:0] value);
      int unsigned      n;
      int unsigned      pos;
      int unsigned      i;
      int               hit;
      bit               have_prev;
      table_result_type res;
      table_result_type prev;
      n = (shadow_size == 0) ? 1 : ((shadow_size > SLOTS) ? SLOTS : shadow_size);
      res = '0;
      res.last = 1'b1;
      have_prev = 1'b0;
      prev = '0;
      case (op)
         lpht_pkg::OP_INSERT: begin
            // Probe forward from the home slot, wrapping at the table size
            res.status = lpht_pkg::STATUS_FULL;
            pos = key % n;
            for (i = 0; i < n && res.status == lpht_pkg::STATUS_FULL; i++) begin
               if (!shadow_valid[pos]) begin
                  shadow_valid[pos] = 1'b1;
                  shadow_key[pos]   = key;
                  shadow_value[pos] = value;
                  res.status = lpht_pkg::STATUS_OK;
                  res.slot   = lpht_pkg::SLOT_OUT_W'(pos);
                  res.key    = key;
                  res.value  = value;
               end
               pos = (pos + 1 == n) ? 0 : pos + 1;
            end
            pending_results.push_back(res);
         end
         lpht_pkg::OP_SEARCH, lpht_pkg::OP_DELETE: begin
            // First matching slot from index 0
            hit = -1;
            for (i = 0; i < n; i++) begin
               if (hit < 0 && shadow_valid[i] && shadow_key[i] == key)
                  hit = i;
            end
            if (hit < 0) begin
               res.status = lpht_pkg::STATUS_MISS;
            end else begin
               res.status = lpht_pkg::STATUS_OK;
               res.slot   = lpht_pkg::SLOT_OUT_W'(hit);
               res.key    = shadow_key[hit];
               res.value  = shadow_value[hit];
               if (op == lpht_pkg::OP_DELETE)
                  shadow_valid[hit] = 1'b0;
            end
            pending_results.push_back(res);
         end
         default: begin
            // One transfer per occupied slot, last flag on the final one; one miss if none is occupied
            for (i = 0; i < n; i++) begin
               if (shadow_valid[i]) begin
                  if (have_prev)
                     pending_results.push_back(prev);
                  prev.status = lpht_pkg::STATUS_OK;
                  prev.slot   = lpht_pkg::SLOT_OUT_W'(i);
                  prev.key    = shadow_key[i];
                  prev.value  = shadow_value[i];
                  prev.last   = 1'b0;
                  have_prev   = 1'b1;
               end
            end
            if (have_prev) begin
               prev.last = 1'b1;
               pending_results.push_back(prev);
            end else begin
               res.status = lpht_pkg::STATUS_MISS;
               pending_results.push_back(res);
            end
         end
      endcase
   endfunction

   // Mostly reuse earlier keys so that searches and deletes hit
   function automatic logic [lpht_pkg::KEY_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (key_pool.size() != 0 && roll < 60)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (roll < 85)
         return lpht_pkg::KEY_W'($urandom_range(0, 300));
      return lpht_pkg::KEY_W'($urandom);
   endfunction

   // Favour small tables and the register extremes
   function automatic logic [lpht_pkg::SIZE_W-1:0] pick_table_size();
      case ($urandom_range(0, 5))
         0:       return lpht_pkg::SIZE_W'($urandom_range(1, 4));
         1:       return lpht_pkg::SIZE_W'(0);
         2:       return lpht_pkg::SIZE_W'(127);
         3:       return lpht_pkg::SIZE_W'(SLOTS);
         default: return lpht_pkg::SIZE_W'($urandom_range(1, SLOTS));
      endcase
   endfunction

   // Drive one request and hold it until the transfer
   task automatic send_item(input logic [lpht_pkg::OP_W-1:0] op,
                            input logic [lpht_pkg::KEY_W-1:0] key,
                            input logic [lpht_pkg::VALUE_W-1:0] value);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= {{(lpht_pkg::REQ_TDATA_W - lpht_pkg::KEY_W - lpht_pkg::VALUE_W){1'b0}},
                     value, key};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_table_op(op, key, value);
   endtask

   // Stop sending and let every outstanding result arrive
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_table_size(input logic [lpht_pkg::SIZE_W-1:0] size);
      wait_idle();
      csr_data  <= size;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      shadow_size = size;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_empty_table();
      send_item(lpht_pkg::OP_DISPLAY, '0, '0);
      send_item(lpht_pkg::OP_SEARCH, '0, '0);
      send_item(lpht_pkg::OP_DELETE, '1, '1);
   endtask

   // Collisions, wrap-around, duplicate keys and a delete of the first of two duplicates
   task automatic test_probe_and_wrap();
      send_item(lpht_pkg::OP_INSERT, '0, '0);
      send_item(lpht_pkg::OP_INSERT, '1, '1);
      send_item(lpht_pkg::OP_INSERT, lpht_pkg::KEY_W'(64), 64'h0123_4567_89ab_cdef);
      send_item(lpht_pkg::OP_INSERT, lpht_pkg::KEY_W'(127), 64'hfedc_ba98_7654_3210);
      send_item(lpht_pkg::OP_INSERT, lpht_pkg::KEY_W'(64), 64'h5a5a_a5a5_0f0f_f0f0);
      send_item(lpht_pkg::OP_SEARCH, lpht_pkg::KEY_W'(64), '0);
      send_item(lpht_pkg::OP_DELETE, lpht_pkg::KEY_W'(64), '0);
      send_item(lpht_pkg::OP_SEARCH, lpht_pkg::KEY_W'(64), '0);
      send_item(lpht_pkg::OP_SEARCH, '1, '0);
      send_item(lpht_pkg::OP_SEARCH, lpht_pkg::KEY_W'(5), '0);
      send_item(lpht_pkg::OP_DISPLAY, '0, '0);
   endtask

   // One-slot table, a size of zero and a size above the slot count
   task automatic test_size_limits();
      write_table_size(lpht_pkg::SIZE_W'(1));
      send_item(lpht_pkg::OP_INSERT, lpht_pkg::KEY_W'(5), 64'h1);
      send_item(lpht_pkg::OP_DELETE, '0, '0);
      send_item(lpht_pkg::OP_INSERT, lpht_pkg::KEY_W'(5), 64'h2);
      send_item(lpht_pkg::OP_SEARCH, '1, '0);
      send_item(lpht_pkg::OP_DISPLAY, '0, '0);
      write_table_size(lpht_pkg::SIZE_W'(0));
      send_item(lpht_pkg::OP_INSERT, lpht_pkg::KEY_W'(9), 64'h3);
      send_item(lpht_pkg::OP_DISPLAY, '0, '0);
      write_table_size(lpht_pkg::SIZE_W'(127));
      send_item(lpht_pkg::OP_DISPLAY, '0, '0);
   endtask

   task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                      input int phases, input int per_phase);
      int                           p;
      int                           i;
      int                           roll;
      logic [lpht_pkg::OP_W-1:0]    op;
      logic [lpht_pkg::KEY_W-1:0]   key;
      logic [lpht_pkg::VALUE_W-1:0] value;
      send_gap_pct   = gap_pct;
      recv_stall_pct = stall_pct;
      for (p = 0; p < phases; p++) begin
         write_table_size(pick_table_size());
         for (i = 0; i < per_phase; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
               op = lpht_pkg::OP_INSERT;
            else if (roll < 65)
               op = lpht_pkg::OP_SEARCH;
            else if (roll < 90)
               op = lpht_pkg::OP_DELETE;
            else
               op = lpht_pkg::OP_DISPLAY;
            key   = pick_key();
            value = {$urandom, $urandom};
            if (op == lpht_pkg::OP_INSERT) begin
               key_pool.push_back(key);
               if (key_pool.size() > POOL_DEPTH)
                  void'(key_pool.pop_front());
            end
            send_item(op, key, value);
         end
      end
   endtask

   // Receiver: stall at random
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin : check_results
      table_result_type got;
      table_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser;
         got.slot   = rsp_tdata[lpht_pkg::SLOT_OUT_W-1:0];
         got.key    = rsp_tdata[lpht_pkg::SLOT_OUT_W +: lpht_pkg::KEY_W];
         got.value  = rsp_tdata[lpht_pkg::SLOT_OUT_W + lpht_pkg::KEY_W +: lpht_pkg::VALUE_W];
         got.last   = rsp_tlast;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("tb: unexpected result status %0d slot %0d key %h value %h last %0b",
                        got.status, got.slot, got.key, got.value, got.last);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("tb: mismatch at %0t", $realtime);
                  $display("tb:   expected status %0d slot %0d key %h value %h last %0b",
                           want.status, want.slot, want.key, want.value, want.last);
                  $display("tb:   actual   status %0d slot %0d key %h value %h last %0b",
                           got.status, got.slot, got.key, got.value, got.last);
               end
            end
         end
      end
   end

   // Stimulus sequence
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = lpht_pkg::OP_INSERT;
      csr_valid  = 1'b0;
      csr_data   = '0;
      shadow_size = lpht_pkg::SIZE_RESET;
      for (int s = 0; s < SLOTS; s++) begin
         shadow_valid[s] = 1'b0;
         shadow_key[s]   = '0;
         shadow_value[s] = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_probe_and_wrap();
      test_size_limits();
      test_random_traffic(29, 85, 4, 34);
      test_random_traffic(85, 29, 4, 34);
      test_random_traffic(0, 0, 4, 34);
      wait_idle();

      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

   // Give up if the run hangs
   initial begin
      #3_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
